/* rtl/core/mexp_pkg.sv */
// Shared types and constants for the modular exponentiation block.
`timescale 1ns / 1ps
package mexp_pkg;

  // Width of every word on the ports.
  localparam int unsigned FIELD_W = 64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_REDUCE,
    ST_STEP,
    ST_MULACC,
    ST_ADVANCE,
    ST_SQUARE,
    ST_DONE
  } ctrl_state_t;

  // Multiplicand source of a modular product; the multiplier is always the base.
  typedef enum logic {
    XSEL_ACC,
    XSEL_BASE
  } xsel_t;

  // Register that takes the finished product.
  typedef enum logic {
    DEST_ACC,
    DEST_BASE
  } dest_t;

  typedef struct packed {
    logic  load;
    logic  mul_start;
    xsel_t x_sel;
    dest_t dest;
    logic  exp_shift;
    logic  out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic exp_lsb;
    logic exp_last;
    logic mul_done;
    logic out_blocked;
  } dp_status_t;

endpackage

/* rtl/core/mexp_dp.sv */
// Datapath: operand registers, bit-serial modular multiplier and result register.
`timescale 1ns / 1ps
module mexp_dp #(
  parameter int unsigned WIDTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [mexp_pkg::FIELD_W-1:0]        cfg_modulus,
  input  logic [mexp_pkg::FIELD_W-1:0]        in_base,
  input  logic [mexp_pkg::FIELD_W-1:0]        in_exponent,
  input  mexp_pkg::ctrl_cmd_t                 cmd,
  output mexp_pkg::dp_status_t                status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mexp_pkg::FIELD_W-1:0]        out_power_result
);
  import mexp_pkg::*;

  logic [WIDTH-1:0]   modulus_r;
  logic [WIDTH-1:0]   base_r,  base_nxt;
  logic [WIDTH-1:0]   exp_r,   exp_nxt;
  logic [WIDTH-1:0]   acc_r,   acc_nxt;
  logic [WIDTH-1:0]   x_r,     x_nxt;
  logic [WIDTH-1:0]   y_r,     y_nxt;
  logic [WIDTH-1:0]   p_r,     p_nxt;
  dest_t              dest_r,  dest_nxt;
  logic               busy_r,  busy_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0] out_data_r,  out_data_nxt;
  logic [WIDTH-1:0]   one_red;
  logic               mul_fin;

  // (a + b) mod m with a, b below m; a zero modulus stands for 2^WIDTH.
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] a,
                                               input logic [WIDTH-1:0] b,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH:0] sum;
    logic [WIDTH:0] diff;
    sum  = {1'b0, a} + {1'b0, b};
    diff = sum - {1'b0, m};
    if (m == '0) begin
      return sum[WIDTH-1:0];
    end else if (sum >= {1'b0, m}) begin
      return diff[WIDTH-1:0];
    end else begin
      return sum[WIDTH-1:0];
    end
  endfunction

  // One modulo the modulus: zero only for a modulus of one.
  assign one_red = (modulus_r == WIDTH'(1)) ? '0 : WIDTH'(1);
  assign mul_fin = busy_r && (y_r == '0);

  always_comb begin
    base_nxt      = base_r;
    exp_nxt       = exp_r;
    acc_nxt       = acc_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    p_nxt         = p_r;
    dest_nxt      = dest_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cmd.load) begin
      base_nxt = in_base[WIDTH-1:0];
      exp_nxt  = in_exponent[WIDTH-1:0];
      // exponent zero gives 1 unreduced
      acc_nxt  = (in_exponent[WIDTH-1:0] == '0) ? WIDTH'(1) : one_red;
    end

    if (cmd.exp_shift) begin
      exp_nxt = exp_r >> 1;
    end

    if (cmd.mul_start) begin
      x_nxt    = (cmd.x_sel == XSEL_ACC) ? acc_r : base_r;
      y_nxt    = base_r;
      p_nxt    = '0;
      dest_nxt = cmd.dest;
      busy_nxt = 1'b1;
    end else if (mul_fin) begin
      busy_nxt = 1'b0;
      if (dest_r == DEST_ACC) begin
        acc_nxt = p_r;
      end else begin
        base_nxt = p_r;
      end
    end else if (busy_r) begin
      // add the multiplicand on a set bit, double it, advance the multiplier
      if (y_r[0]) begin
        p_nxt = add_mod(p_r, x_r, modulus_r);
      end
      x_nxt = add_mod(x_r, x_r, modulus_r);
      y_nxt = y_r >> 1;
    end

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = FIELD_W'(acc_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r   <= WIDTH'(1);
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        modulus_r <= cfg_modulus[WIDTH-1:0];
      end
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r     <= base_nxt;
    exp_r      <= exp_nxt;
    acc_r      <= acc_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    p_r        <= p_nxt;
    dest_r     <= dest_nxt;
    out_data_r <= out_data_nxt;
  end

  assign status.exp_zero    = (exp_r == '0);
  assign status.exp_lsb     = exp_r[0];
  assign status.exp_last    = (exp_r[WIDTH-1:1] == '0);
  assign status.mul_done    = mul_fin;
  assign status.out_blocked = out_valid_r && !out_ready;

  assign out_valid        = out_valid_r;
  assign out_power_result = out_data_r;

endmodule

/* rtl/core/mexp_ctrl.sv */
// Controller: sequences the square-and-multiply steps over the datapath.
`timescale 1ns / 1ps
module mexp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mexp_pkg::dp_status_t status,
  output mexp_pkg::ctrl_cmd_t  cmd
);
  import mexp_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.mul_start = 1'b0;
    cmd.x_sel     = XSEL_ACC;
    cmd.dest      = DEST_ACC;
    cmd.exp_shift = 1'b0;
    cmd.out_load  = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        if (status.exp_zero) begin
          state_nxt = ST_DONE;
        end else begin
          // reduce the base: (1 mod m) times base
          cmd.mul_start = 1'b1;
          cmd.x_sel     = XSEL_ACC;
          cmd.dest      = DEST_BASE;
          state_nxt     = ST_REDUCE;
        end
      end
      ST_REDUCE, ST_SQUARE: begin
        if (status.mul_done) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (status.exp_lsb) begin
          cmd.mul_start = 1'b1;
          cmd.x_sel     = XSEL_ACC;
          cmd.dest      = DEST_ACC;
          state_nxt     = ST_MULACC;
        end else begin
          state_nxt = ST_ADVANCE;
        end
      end
      ST_MULACC: begin
        if (status.mul_done) begin
          state_nxt = ST_ADVANCE;
        end
      end
      ST_ADVANCE: begin
        cmd.exp_shift = 1'b1;
        if (status.exp_last) begin
          // no bits left: the final square is not needed
          state_nxt = ST_DONE;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.x_sel     = XSEL_BASE;
          cmd.dest      = DEST_BASE;
          state_nxt     = ST_SQUARE;
        end
      end
      ST_DONE: begin
        if (!status.out_blocked) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/modular_exponentiation.sv */
// Top level of the modular exponentiation block.
//
//  channel  direction  words                   handshake
//  cfg      in         cfg_modulus             cfg_valid / cfg_ready
//  in       in         in_base, in_exponent    in_valid / in_ready
//  out      out        out_power_result        out_valid / out_ready
//
// One word is worked at a time; each modular product runs bit-serially, over the
// significant multiplier bits, on a single shift-and-add unit.
// Reset leaves the modulus at 1 and the block idle; cfg_ready is always high.
// A held result stalls the final write-back, and no new word is taken until it is written.
`timescale 1ns / 1ps
module modular_exponentiation #(
  parameter int unsigned WIDTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mexp_pkg::FIELD_W-1:0] cfg_modulus,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [mexp_pkg::FIELD_W-1:0] in_base,
  input  logic [mexp_pkg::FIELD_W-1:0] in_exponent,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mexp_pkg::FIELD_W-1:0] out_power_result
);
  import mexp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  mexp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mexp_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_modulus      (cfg_modulus),
    .in_base          (in_base),
    .in_exponent      (in_exponent),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_power_result (out_power_result)
  );

endmodule

/* rtl/core/mexp_checker.sv */
// Port-level checks for the modular exponentiation block, bound to the top level.
`timescale 1ns / 1ps
module mexp_checker #(
  parameter int unsigned WIDTH = 64
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         cfg_valid,
  input logic                         cfg_ready,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [mexp_pkg::FIELD_W-1:0] in_base,
  input logic [mexp_pkg::FIELD_W-1:0] in_exponent,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [mexp_pkg::FIELD_W-1:0] out_power_result
);
  import mexp_pkg::*;

  // A held result keeps its word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_power_result))
    else $error("result changed while stalled");

  // One word in flight: input closes right after an accept.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while busy");

  // A waiting input word keeps its fields.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_base) && $stable(in_exponent))
    else $error("input word changed while waiting");

  // Results stay inside the datapath width.
  a_result_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_power_result >> WIDTH) == '0)
    else $error("result wider than datapath");

  // Configuration is always taken.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind modular_exponentiation mexp_checker #(.WIDTH(WIDTH)) u_mexp_checker (.*);
